// ===== rtl/tagged_value_stream_parser_top_assert.svh =====
// Assertion helpers used by the checker file.
`ifndef TAGGED_VALUE_STREAM_PARSER_TOP_ASSERT_SVH
`define TAGGED_VALUE_STREAM_PARSER_TOP_ASSERT_SVH

// same-cycle implication
`define TVSP_ASSERT_IMP(lbl, ck, rstn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!(rstn)) (ante) |-> (cons)) \
		else $error("tvsp assertion failed");

// next-cycle implication
`define TVSP_ASSERT_NXT(lbl, ck, rstn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!(rstn)) (ante) |=> (cons)) \
		else $error("tvsp assertion failed");

`endif

// ===== rtl/tvsp_pkg.sv =====
package tvsp_pkg;

	localparam int unsigned MAX_DEPTH_DFLT = 32;

	// tag bytes
	localparam logic [7:0] TAG_NULL   = 8'h00;
	localparam logic [7:0] TAG_TRUE   = 8'h02;
	localparam logic [7:0] TAG_INT    = 8'h03;
	localparam logic [7:0] TAG_DBL    = 8'h04;
	localparam logic [7:0] TAG_STR    = 8'h05;
	localparam logic [7:0] TAG_UNUSED = 8'h06;
	localparam logic [7:0] TAG_SEQ    = 8'h07;
	localparam logic [7:0] TAG_OBJ    = 8'h08;
	localparam logic [7:0] TAG_SET    = 8'h09;

	localparam logic [3:0] VARINT_LAST_IDX = 4'd9;
	localparam logic [31:0] DBL_BYTES = 32'd8;

	// token kinds
	localparam logic [3:0] KIND_NONE  = 4'd0;
	localparam logic [3:0] KIND_INT   = 4'd4;
	localparam logic [3:0] KIND_DBL   = 4'd5;
	localparam logic [3:0] KIND_STRS  = 4'd6;
	localparam logic [3:0] KIND_STRB  = 4'd7;
	localparam logic [3:0] KIND_SEQ   = 4'd8;
	localparam logic [3:0] KIND_SET   = 4'd9;
	localparam logic [3:0] KIND_OBJ   = 4'd10;

	// error codes
	localparam logic [2:0] ERR_OK    = 3'd0;
	localparam logic [2:0] ERR_TRUNC = 3'd1;
	localparam logic [2:0] ERR_OVER  = 3'd2;
	localparam logic [2:0] ERR_CNT   = 3'd3;
	localparam logic [2:0] ERR_DEEP  = 3'd4;
	localparam logic [2:0] ERR_TAG   = 3'd5;
	localparam logic [2:0] ERR_KEY   = 3'd6;
	localparam logic [2:0] ERR_TRAIL = 3'd7;

	typedef enum logic [2:0] {
		PH_TAG, PH_VARINT, PH_DOUBLE, PH_STRING, PH_DONE, PH_SKIP
	} phase_t;

	typedef enum logic [2:0] {
		S_IDLE, S_FETCH, S_EXEC, S_CFETCH, S_CLOSE, S_FIN
	} seq_t;

	typedef struct packed {
		logic [7:0]  data_byte;
		logic [31:0] bytes_after;
	} in_beat_t;

	typedef struct packed {
		logic [3:0]  token_kind;
		logic [63:0] token_value;
		logic [5:0]  token_depth;
		logic        is_key;
		logic [5:0]  levels_closed;
		logic        message_done;
		logic [2:0]  error_code;
	} tok_beat_t;

	typedef struct packed {
		logic [31:0] count;
		logic        is_obj;
		logic        expect_key;
	} level_t;

endpackage

// ===== rtl/tvsp_stack.sv =====
module tvsp_stack #(
	parameter int unsigned DEPTH = tvsp_pkg::MAX_DEPTH_DFLT,
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [AW-1:0]     wr_addr,
	input  tvsp_pkg::level_t  wr_data,
	input  logic              rd_en,
	input  logic [AW-1:0]     rd_addr,
	output tvsp_pkg::level_t  rd_data
);

	tvsp_pkg::level_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ===== rtl/tagged_value_stream_parser_top.sv =====
// Tagged value stream parser: checks a tagged binary message byte by byte.
// Input channel byte_*: one beat per message byte with the count of bytes
// still to follow (0 marks the last byte). Output channel tok_*: exactly one
// token beat per input beat, in order.
// Each byte passes through capture, stack read, execute and emit steps.
// A byte that completes a value while a container is open adds a step
// to update the innermost level; each level it pops that leaves another
// level open beneath adds a further stack read and update, since the
// level stack is a single-port-read memory walked one level per step by
// the sequencer. byte_stall is high from the accepted beat until its token
// is placed in the output register.
// The output register decouples the sides: a finished token waits there
// while tok_stall is high and the next byte is still accepted and worked;
// its token then waits in the sequencer until the register frees up.
// Reset (arst_n low) empties the output register, clears nesting depth and
// the parse phase. Stack entries are not cleared; they are written before
// use. The last byte of each message returns all parse state to reset.
// MAX_DEPTH sets the stack size; token_depth reports the low six bits.
module tagged_value_stream_parser_top #(
	parameter int unsigned MAX_DEPTH = tvsp_pkg::MAX_DEPTH_DFLT
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                byte_valid,
	output logic                byte_stall,
	input  tvsp_pkg::in_beat_t  byte_beat,
	output logic                tok_valid,
	input  logic                tok_stall,
	output tvsp_pkg::tok_beat_t tok_beat
);

	localparam int unsigned AW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
	localparam int unsigned OW = $clog2(MAX_DEPTH + 1);

	tvsp_pkg::seq_t   state_q, state_d;
	tvsp_pkg::phase_t phase_q;

	// captured beat
	logic [7:0]  byte_q;
	logic [31:0] after_q;

	// parse state
	logic [3:0]    tag_q;
	logic [63:0]   vint_q;
	logic [3:0]    vidx_q;
	logic [31:0]   cnt_q;
	logic [63:0]   dbl_q;
	logic [OW-1:0] open_q;
	logic [OW-1:0] top_m1;

	// token under construction
	logic [3:0]  kind_q;
	logic [63:0] val_q;
	logic [5:0]  depth_q;
	logic        key_q;
	logic [5:0]  closed_q;
	logic [2:0]  err_q;
	logic        cmpl_q;

	logic                out_valid_q;
	tvsp_pkg::tok_beat_t out_q;

	// stack port
	logic             st_wr_en, st_rd_en;
	logic [AW-1:0]    st_wr_addr;
	tvsp_pkg::level_t st_wr_data, rd;

	// execute results
	logic             key_pos;
	logic [6:0]       sh7;
	logic [63:0]      acc;
	logic [63:0]      limit;
	logic             obj;
	logic [3:0]       e_kind, e_tag, e_vidx;
	logic [63:0]      e_val, e_vint, e_dbl;
	logic             e_key, e_cmpl, e_push;
	logic [2:0]       e_err;
	logic [31:0]      e_cnt;
	tvsp_pkg::phase_t e_phase;

	// close step
	logic [31:0] c_dec;
	logic        c_brk, c_pop;

	// finish
	tvsp_pkg::phase_t    f_ph;
	logic                f_done;
	logic [2:0]          f_err;
	logic                load;
	tvsp_pkg::tok_beat_t f_beat;

	assign top_m1 = open_q - 1'b1;

	tvsp_stack #(.DEPTH(MAX_DEPTH)) u_stack (
		.clk     (clk),
		.wr_en   (st_wr_en),
		.wr_addr (st_wr_addr),
		.wr_data (st_wr_data),
		.rd_en   (st_rd_en),
		.rd_addr (top_m1[AW-1:0]),
		.rd_data (rd)
	);

	// shift amount 7*index; index never passes 9
	assign sh7 = {vidx_q, 3'b000} - {3'b000, vidx_q};
	assign acc = vint_q | ({57'd0, byte_q[6:0]} << sh7[5:0]);
	assign key_pos = (open_q != '0) && rd.is_obj && rd.expect_key;

	always_comb begin
		e_kind  = tvsp_pkg::KIND_NONE;
		e_val   = '0;
		e_key   = 1'b0;
		e_err   = tvsp_pkg::ERR_OK;
		e_cmpl  = 1'b0;
		e_push  = 1'b0;
		e_phase = phase_q;
		e_tag   = tag_q;
		e_vint  = vint_q;
		e_vidx  = vidx_q;
		e_cnt   = cnt_q;
		e_dbl   = dbl_q;
		obj     = (tag_q == tvsp_pkg::TAG_OBJ[3:0]);
		limit   = obj ? {33'd0, after_q[31:1]} : {32'd0, after_q};
		unique case (phase_q)
			tvsp_pkg::PH_TAG: begin
				if (key_pos && byte_q != tvsp_pkg::TAG_STR) begin
					e_err = (byte_q <= tvsp_pkg::TAG_SET && byte_q != tvsp_pkg::TAG_UNUSED)
						? tvsp_pkg::ERR_KEY : tvsp_pkg::ERR_TAG;
				end else if (byte_q <= tvsp_pkg::TAG_TRUE) begin
					e_kind = byte_q[3:0] + 4'd1;
					e_cmpl = 1'b1;
				end else if (byte_q == tvsp_pkg::TAG_INT || byte_q == tvsp_pkg::TAG_STR
					|| byte_q == tvsp_pkg::TAG_SEQ || byte_q == tvsp_pkg::TAG_OBJ
					|| byte_q == tvsp_pkg::TAG_SET) begin
					e_tag   = byte_q[3:0];
					e_vint  = '0;
					e_vidx  = '0;
					e_phase = tvsp_pkg::PH_VARINT;
				end else if (byte_q == tvsp_pkg::TAG_DBL) begin
					if (after_q < tvsp_pkg::DBL_BYTES) begin
						e_err = tvsp_pkg::ERR_TRUNC;
					end else begin
						e_dbl   = '0;
						e_cnt   = tvsp_pkg::DBL_BYTES;
						e_phase = tvsp_pkg::PH_DOUBLE;
					end
				end else begin
					e_err = tvsp_pkg::ERR_TAG;
				end
			end
			tvsp_pkg::PH_VARINT: begin
				if (vidx_q >= tvsp_pkg::VARINT_LAST_IDX && byte_q > 8'd1) begin
					e_err = tvsp_pkg::ERR_OVER;
				end else begin
					e_vint = acc;
					if (byte_q[7]) begin
						e_vidx = vidx_q + 4'd1;
					end else begin
						e_phase = tvsp_pkg::PH_TAG;
						if (tag_q == tvsp_pkg::TAG_INT[3:0]) begin
							e_kind = tvsp_pkg::KIND_INT;
							e_val  = {1'b0, acc[63:1]} ^ {64{acc[0]}};
							e_cmpl = 1'b1;
						end else if (tag_q == tvsp_pkg::TAG_STR[3:0]) begin
							if (acc > {32'd0, after_q}) begin
								e_err = tvsp_pkg::ERR_CNT;
							end else begin
								e_kind = tvsp_pkg::KIND_STRS;
								e_val  = acc;
								e_key  = key_pos;
								if (acc == '0) begin
									e_cmpl = 1'b1;
								end else begin
									e_cnt   = acc[31:0];
									e_phase = tvsp_pkg::PH_STRING;
								end
							end
						end else begin
							if (acc > limit) begin
								e_err = tvsp_pkg::ERR_CNT;
							end else begin
								e_kind = obj ? tvsp_pkg::KIND_OBJ
									: (tag_q == tvsp_pkg::TAG_SET[3:0]
										? tvsp_pkg::KIND_SET : tvsp_pkg::KIND_SEQ);
								e_val = acc;
								if (acc == '0) begin
									e_cmpl = 1'b1;
								end else if (open_q >= OW'(MAX_DEPTH)) begin
									e_err = tvsp_pkg::ERR_DEEP;
								end else begin
									e_push = 1'b1;
								end
							end
						end
					end
				end
			end
			tvsp_pkg::PH_DOUBLE: begin
				e_dbl = {dbl_q[55:0], byte_q};
				e_cnt = cnt_q - 32'd1;
				if (cnt_q == 32'd1) begin
					e_kind  = tvsp_pkg::KIND_DBL;
					e_val   = {dbl_q[55:0], byte_q};
					e_cmpl  = 1'b1;
					e_phase = tvsp_pkg::PH_TAG;
				end
			end
			tvsp_pkg::PH_STRING: begin
				e_kind = tvsp_pkg::KIND_STRB;
				e_val  = {56'd0, byte_q};
				e_key  = key_pos;
				e_cnt  = cnt_q - 32'd1;
				if (cnt_q == 32'd1) begin
					e_cmpl  = 1'b1;
					e_phase = tvsp_pkg::PH_TAG;
				end
			end
			tvsp_pkg::PH_DONE: e_err = tvsp_pkg::ERR_TRAIL;
			default: ;
		endcase
	end

	// one level of the close cascade
	assign c_brk = rd.is_obj && rd.expect_key;
	assign c_dec = (rd.count != '0) ? rd.count - 32'd1 : rd.count;
	assign c_pop = !c_brk && (c_dec == '0);

	always_comb begin
		st_wr_en   = 1'b0;
		st_wr_addr = top_m1[AW-1:0];
		st_wr_data = rd;
		if (state_q == tvsp_pkg::S_EXEC && e_push) begin
			st_wr_en   = 1'b1;
			st_wr_addr = open_q[AW-1:0];
			st_wr_data = '{count: e_val[31:0], is_obj: obj, expect_key: obj};
		end else if (state_q == tvsp_pkg::S_CLOSE && !c_pop) begin
			st_wr_en = 1'b1;
			if (c_brk) begin
				st_wr_data = '{count: rd.count, is_obj: rd.is_obj, expect_key: 1'b0};
			end else begin
				st_wr_data = '{count: c_dec, is_obj: rd.is_obj,
					expect_key: rd.is_obj | rd.expect_key};
			end
		end
	end

	assign st_rd_en = (state_q == tvsp_pkg::S_FETCH) || (state_q == tvsp_pkg::S_CFETCH);

	// finishing checks and token assembly
	always_comb begin
		f_ph   = (cmpl_q && err_q == tvsp_pkg::ERR_OK && open_q == '0)
			? tvsp_pkg::PH_DONE : phase_q;
		f_done = (f_ph == tvsp_pkg::PH_DONE) && cmpl_q && (after_q == '0);
		f_err  = err_q;
		if (err_q == tvsp_pkg::ERR_OK && after_q == '0 && !f_done
			&& f_ph != tvsp_pkg::PH_SKIP) begin
			f_err = tvsp_pkg::ERR_TRUNC;
		end
		f_beat = '{token_kind: kind_q, token_value: val_q, token_depth: depth_q,
			is_key: key_q, levels_closed: closed_q, message_done: f_done,
			error_code: f_err};
		if (f_err != tvsp_pkg::ERR_OK) begin
			f_ph                 = tvsp_pkg::PH_SKIP;
			f_beat.token_kind    = tvsp_pkg::KIND_NONE;
			f_beat.token_value   = '0;
			f_beat.is_key        = 1'b0;
			f_beat.levels_closed = '0;
			f_beat.message_done  = 1'b0;
		end
	end

	assign load       = (state_q == tvsp_pkg::S_FIN) && (!out_valid_q || !tok_stall);
	assign byte_stall = (state_q != tvsp_pkg::S_IDLE);
	assign tok_valid  = out_valid_q;
	assign tok_beat   = out_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			tvsp_pkg::S_IDLE:   if (byte_valid) state_d = tvsp_pkg::S_FETCH;
			tvsp_pkg::S_FETCH:  state_d = tvsp_pkg::S_EXEC;
			tvsp_pkg::S_EXEC: begin
				state_d = (e_cmpl && e_err == tvsp_pkg::ERR_OK && open_q != '0)
					? tvsp_pkg::S_CLOSE : tvsp_pkg::S_FIN;
			end
			tvsp_pkg::S_CFETCH: state_d = tvsp_pkg::S_CLOSE;
			tvsp_pkg::S_CLOSE: begin
				if (c_pop && top_m1 != '0) begin
					state_d = tvsp_pkg::S_CFETCH;
				end else begin
					state_d = tvsp_pkg::S_FIN;
				end
			end
			tvsp_pkg::S_FIN:    if (load) state_d = tvsp_pkg::S_IDLE;
			default:            state_d = tvsp_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tvsp_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// parse state and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= tvsp_pkg::PH_TAG;
			tag_q       <= '0;
			vint_q      <= '0;
			vidx_q      <= '0;
			cnt_q       <= '0;
			dbl_q       <= '0;
			open_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == tvsp_pkg::S_EXEC) begin
				phase_q <= e_phase;
				tag_q   <= e_tag;
				vint_q  <= e_vint;
				vidx_q  <= e_vidx;
				cnt_q   <= e_cnt;
				dbl_q   <= e_dbl;
				if (e_push) begin
					open_q <= open_q + 1'b1;
				end
			end
			if (state_q == tvsp_pkg::S_CLOSE && c_pop) begin
				open_q <= top_m1;
			end
			if (load) begin
				out_valid_q <= 1'b1;
				if (after_q == '0) begin
					phase_q <= tvsp_pkg::PH_TAG;
					tag_q   <= '0;
					vint_q  <= '0;
					vidx_q  <= '0;
					cnt_q   <= '0;
					dbl_q   <= '0;
					open_q  <= '0;
				end else begin
					phase_q <= f_ph;
				end
			end else if (tok_valid && !tok_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (state_q == tvsp_pkg::S_IDLE && byte_valid) begin
			byte_q  <= byte_beat.data_byte;
			after_q <= byte_beat.bytes_after;
		end
		if (state_q == tvsp_pkg::S_EXEC) begin
			kind_q   <= e_kind;
			val_q    <= e_val;
			key_q    <= e_key;
			err_q    <= e_err;
			cmpl_q   <= e_cmpl;
			depth_q  <= 6'(open_q);
			closed_q <= '0;
		end
		if (state_q == tvsp_pkg::S_CLOSE && c_pop) begin
			closed_q <= closed_q + 6'd1;
		end
		if (load) begin
			out_q <= f_beat;
		end
	end

endmodule

// ===== rtl/tvsp_check.sv =====
`include "tagged_value_stream_parser_top_assert.svh"

module tvsp_check (
	input logic                clk,
	input logic                arst_n,
	input logic                byte_valid,
	input logic                byte_stall,
	input tvsp_pkg::in_beat_t  byte_beat,
	input logic                tok_valid,
	input logic                tok_stall,
	input tvsp_pkg::tok_beat_t tok_beat
);

	`TVSP_ASSERT_IMP(a_err_clears, clk, arst_n, tok_valid && (tok_beat.error_code != tvsp_pkg::ERR_OK), (tok_beat.token_kind == tvsp_pkg::KIND_NONE) && (tok_beat.message_done == 1'b0) && (tok_beat.levels_closed == 6'd0) && (tok_beat.token_value == 64'd0))
	`TVSP_ASSERT_IMP(a_kind_range, clk, arst_n, tok_valid, tok_beat.token_kind <= tvsp_pkg::KIND_OBJ)
	`TVSP_ASSERT_NXT(a_busy_after_beat, clk, arst_n, byte_valid && !byte_stall && (byte_beat.bytes_after != 32'd0 || byte_beat.data_byte != 8'hFF || 1'b1), byte_stall)
	`TVSP_ASSERT_NXT(a_tok_hold, clk, arst_n, tok_valid && tok_stall, tok_valid && $stable(tok_beat))

endmodule

bind tagged_value_stream_parser_top tvsp_check u_check (.*);

// ===== verif/tagged_value_stream_parser_top_test.sv =====
module tagged_value_stream_parser_top_test;

	// nesting limit of the block (default parameter)
	localparam int unsigned DEPTH_LIMIT = tvsp_pkg::MAX_DEPTH_DFLT;

	// tags the package does not name
	localparam logic [7:0] TAG_FALSE = 8'h01;
	localparam logic [7:0] TAG_BAD = 8'h0A;
	// token kinds the package does not name
	localparam logic [3:0] KIND_NULL = 4'd1;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic byte_valid = 1'b0;
	logic byte_stall;
	tvsp_pkg::in_beat_t byte_beat = '0;
	logic tok_valid;
	logic tok_stall = 1'b0;
	tvsp_pkg::tok_beat_t tok_beat;

	tagged_value_stream_parser_top uut (
		.clk(clk),
		.arst_n(arst_n),
		.byte_valid(byte_valid),
		.byte_stall(byte_stall),
		.byte_beat(byte_beat),
		.tok_valid(tok_valid),
		.tok_stall(tok_stall),
		.tok_beat(tok_beat)
	);

	always #5 clk = ~clk;

	// ---------------------------------------------------------------
	// Parser state mirror
	// ---------------------------------------------------------------
	tvsp_pkg::phase_t pr_phase;
	logic [7:0]  pr_tag;
	logic [63:0] pr_varint;
	int unsigned pr_vidx;
	logic [63:0] pr_left;
	logic [63:0] pr_dbl;
	int unsigned pr_open;
	logic [31:0] pr_count [DEPTH_LIMIT];
	logic        pr_obj [DEPTH_LIMIT];
	logic        pr_want_key [DEPTH_LIMIT];

	tvsp_pkg::tok_beat_t tokens_due [$];
	tvsp_pkg::in_beat_t  bytes_to_send [$];
	int          fail_count = 0;
	int          beats_sent = 0;
	bit          quiet_tail = 0;
	bit          hold_sender = 0;

	// long receiver hold, counted in its own process
	bit          hold_go = 0;
	int          hold_cycles = 0;
	logic        long_hold;

	function automatic void parser_clear();
		pr_phase = tvsp_pkg::PH_TAG;
		pr_tag = '0;
		pr_varint = '0;
		pr_vidx = 0;
		pr_left = '0;
		pr_dbl = '0;
		pr_open = 0;
		for (int i = 0; i < DEPTH_LIMIT; i++) begin
			pr_count[i] = '0;
			pr_obj[i] = 1'b0;
			pr_want_key[i] = 1'b0;
		end
	endfunction

	// next token for one message byte; updates the mirror
	function automatic tvsp_pkg::tok_beat_t parse_byte(tvsp_pkg::in_beat_t ib);
		tvsp_pkg::tok_beat_t t;
		logic [7:0] b;
		logic [63:0] aft, n, lim;
		bit done_val, key_pos, obj;
		logic [2:0] err;
		int unsigned top;
		b = ib.data_byte;
		aft = {32'd0, ib.bytes_after};
		t = '0;
		err = tvsp_pkg::ERR_OK;
		done_val = 0;
		key_pos = 0;
		t.token_depth = pr_open[5:0];
		if (pr_open > 0 && pr_open <= DEPTH_LIMIT)
			key_pos = pr_obj[pr_open - 1] && pr_want_key[pr_open - 1];
		case (pr_phase)
			tvsp_pkg::PH_TAG: begin
				if (key_pos && b != tvsp_pkg::TAG_STR) begin
					err = (b <= tvsp_pkg::TAG_SET && b != tvsp_pkg::TAG_UNUSED)
						? tvsp_pkg::ERR_KEY : tvsp_pkg::ERR_TAG;
				end else if (b <= tvsp_pkg::TAG_TRUE) begin
					t.token_kind = b[3:0] + KIND_NULL;
					done_val = 1;
				end else if (b == tvsp_pkg::TAG_INT || b == tvsp_pkg::TAG_STR ||
						b == tvsp_pkg::TAG_SEQ || b == tvsp_pkg::TAG_OBJ ||
						b == tvsp_pkg::TAG_SET) begin
					pr_tag = b;
					pr_varint = '0;
					pr_vidx = 0;
					pr_phase = tvsp_pkg::PH_VARINT;
				end else if (b == tvsp_pkg::TAG_DBL) begin
					if (aft < 64'd8) begin
						err = tvsp_pkg::ERR_TRUNC;
					end else begin
						pr_dbl = '0;
						pr_left = 64'd8;
						pr_phase = tvsp_pkg::PH_DOUBLE;
					end
				end else begin
					err = tvsp_pkg::ERR_TAG;
				end
			end
			tvsp_pkg::PH_VARINT: begin
				if (pr_vidx >= tvsp_pkg::VARINT_LAST_IDX && b > 8'd1) begin
					err = tvsp_pkg::ERR_OVER;
				end else begin
					pr_varint |= {57'd0, b[6:0]} << ((7 * pr_vidx) % 64);
					if (b[7]) begin
						pr_vidx++;
					end else begin
						n = pr_varint;
						pr_phase = tvsp_pkg::PH_TAG;
						if (pr_tag == tvsp_pkg::TAG_INT) begin
							t.token_kind = tvsp_pkg::KIND_INT;
							t.token_value = (n >> 1) ^ (64'd0 - {63'd0, n[0]});
							done_val = 1;
						end else if (pr_tag == tvsp_pkg::TAG_STR) begin
							if (n > aft) begin
								err = tvsp_pkg::ERR_CNT;
							end else begin
								t.token_kind = tvsp_pkg::KIND_STRS;
								t.token_value = n;
								t.is_key = key_pos;
								if (n == 64'd0) begin
									done_val = 1;
								end else begin
									pr_left = n;
									pr_phase = tvsp_pkg::PH_STRING;
								end
							end
						end else begin
							obj = (pr_tag == tvsp_pkg::TAG_OBJ);
							lim = obj ? aft / 2 : aft;
							if (n > lim) begin
								err = tvsp_pkg::ERR_CNT;
							end else begin
								t.token_kind = obj ? tvsp_pkg::KIND_OBJ :
									(pr_tag == tvsp_pkg::TAG_SET ?
										tvsp_pkg::KIND_SET : tvsp_pkg::KIND_SEQ);
								t.token_value = n;
								if (n == 64'd0) begin
									done_val = 1;
								end else if (pr_open >= DEPTH_LIMIT) begin
									err = tvsp_pkg::ERR_DEEP;
								end else begin
									pr_count[pr_open] = n[31:0];
									pr_obj[pr_open] = obj;
									pr_want_key[pr_open] = obj;
									pr_open++;
								end
							end
						end
					end
				end
			end
			tvsp_pkg::PH_DOUBLE: begin
				pr_dbl = {pr_dbl[55:0], b};
				pr_left--;
				if (pr_left == 64'd0) begin
					t.token_kind = tvsp_pkg::KIND_DBL;
					t.token_value = pr_dbl;
					done_val = 1;
					pr_phase = tvsp_pkg::PH_TAG;
				end
			end
			tvsp_pkg::PH_STRING: begin
				t.token_kind = tvsp_pkg::KIND_STRB;
				t.token_value = {56'd0, b};
				t.is_key = key_pos;
				pr_left--;
				if (pr_left == 64'd0) begin
					done_val = 1;
					pr_phase = tvsp_pkg::PH_TAG;
				end
			end
			tvsp_pkg::PH_DONE: err = tvsp_pkg::ERR_TRAIL;
			default: ;
		endcase
		if (done_val && err == tvsp_pkg::ERR_OK) begin
			// close finished containers, innermost first
			while (pr_open > 0) begin
				top = pr_open - 1;
				if (pr_obj[top] && pr_want_key[top]) begin
					pr_want_key[top] = 1'b0;
					break;
				end
				if (pr_count[top] > 0)
					pr_count[top]--;
				if (pr_obj[top])
					pr_want_key[top] = 1'b1;
				if (pr_count[top] != 0)
					break;
				pr_open--;
				t.levels_closed++;
			end
			if (pr_open == 0) begin
				pr_phase = tvsp_pkg::PH_DONE;
				if (aft == 64'd0)
					t.message_done = 1'b1;
			end
		end
		if (err == tvsp_pkg::ERR_OK && aft == 64'd0 && !t.message_done &&
				pr_phase != tvsp_pkg::PH_SKIP)
			err = tvsp_pkg::ERR_TRUNC;
		if (err != tvsp_pkg::ERR_OK) begin
			t.token_kind = tvsp_pkg::KIND_NONE;
			t.token_value = '0;
			t.is_key = 1'b0;
			t.levels_closed = '0;
			t.message_done = 1'b0;
			pr_phase = tvsp_pkg::PH_SKIP;
		end
		t.error_code = err;
		if (aft == 64'd0)
			parser_clear();
		return t;
	endfunction

	// ---------------------------------------------------------------
	// Message builders: values go into a byte list, then bytes_after is
	// attached when the message is queued
	// ---------------------------------------------------------------
	logic [7:0] msg [$];

	function automatic void put_varint(logic [63:0] v);
		do begin
			msg.push_back({(v >> 7) != 0, v[6:0]});
			v = v >> 7;
		end while (v != 0);
	endfunction

	function automatic void put_int(logic [63:0] s);
		msg.push_back(tvsp_pkg::TAG_INT);
		put_varint((s << 1) ^ {64{s[63]}});
	endfunction

	function automatic void put_str(int len);
		msg.push_back(tvsp_pkg::TAG_STR);
		put_varint(64'(len));
		repeat (len) msg.push_back(8'($urandom_range(0, 255)));
	endfunction

	function automatic void put_dbl();
		msg.push_back(tvsp_pkg::TAG_DBL);
		repeat (8) msg.push_back(8'($urandom_range(0, 255)));
	endfunction

	// random well-formed value
	function automatic void put_value(int lvl);
		int pick, cnt;
		logic [63:0] r;
		pick = (lvl >= 4) ? $urandom_range(0, 4) : $urandom_range(0, 7);
		case (pick)
			0: msg.push_back(8'($urandom_range(0, 2)));
			1: begin
				r = {$urandom, $urandom};
				r = r >> $urandom_range(0, 63);
				if ($urandom_range(0, 1))
					r = ~r;
				put_int(r);
			end
			2: put_dbl();
			3, 4: put_str($urandom_range(0, 6));
			5, 6: begin
				cnt = $urandom_range(0, 3);
				msg.push_back(pick == 5 ? tvsp_pkg::TAG_SEQ : tvsp_pkg::TAG_SET);
				put_varint(64'(cnt));
				repeat (cnt) put_value(lvl + 1);
			end
			default: begin
				cnt = $urandom_range(0, 3);
				msg.push_back(tvsp_pkg::TAG_OBJ);
				put_varint(64'(cnt));
				repeat (cnt) begin
					put_str($urandom_range(0, 3));
					put_value(lvl + 1);
				end
			end
		endcase
	endfunction

	// queue the built message with correct remaining counts
	function automatic void send_msg();
		tvsp_pkg::in_beat_t ib;
		for (int i = 0; i < msg.size(); i++) begin
			ib.data_byte = msg[i];
			ib.bytes_after = 32'(msg.size() - 1 - i);
			bytes_to_send.push_back(ib);
		end
		msg.delete();
	endfunction

	function automatic void send_raw(logic [7:0] b, logic [31:0] aft);
		tvsp_pkg::in_beat_t ib;
		ib.data_byte = b;
		ib.bytes_after = aft;
		bytes_to_send.push_back(ib);
	endfunction

	// random damage: drop tail, flip a byte, or append trailing bytes
	function automatic void damage_msg();
		int k;
		k = $urandom_range(0, 3);
		if (k == 0 && msg.size() > 1)
			msg = msg[0:$urandom_range(0, msg.size() - 2)];
		else if (k == 1)
			msg[$urandom_range(0, msg.size() - 1)] = 8'($urandom_range(0, 255));
		else if (k == 2)
			repeat ($urandom_range(1, 3)) msg.push_back(8'($urandom_range(0, 255)));
	endfunction

	// acceptance flag captured at the rising edge
	bit took_byte = 0;

	// ---------------------------------------------------------------
	// Driver: new beat offered at the falling edge, with idle bursts
	// ---------------------------------------------------------------
	int idle_left = 0;
	always @(negedge clk) begin
		if (arst_n) begin
			if (!byte_valid || took_byte) begin
				if (idle_left > 0) begin
					idle_left <= idle_left - 1;
					byte_valid <= 1'b0;
				end else if (bytes_to_send.size() > 0 && !hold_sender) begin
					byte_beat <= bytes_to_send.pop_front();
					byte_valid <= 1'b1;
					if (!quiet_tail && $urandom_range(0, 5) == 0)
						idle_left <= $urandom_range(1, 15);
				end else begin
					byte_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		took_byte <= byte_valid && !byte_stall;
		if (byte_valid && !byte_stall) begin
			tokens_due.push_back(parse_byte(byte_beat));
			beats_sent <= beats_sent + 1;
		end
	end

	// ---------------------------------------------------------------
	// Receiver stall and token monitor
	// ---------------------------------------------------------------
	assign long_hold = hold_go && (hold_cycles < 200);

	always @(negedge clk) begin
		if (long_hold)
			hold_cycles <= hold_cycles + 1;
	end

	int stall_left = 0;
	always @(negedge clk) begin
		if (long_hold) begin
			tok_stall <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			tok_stall <= 1'b1;
		end else if (!quiet_tail && $urandom_range(0, 7) == 0) begin
			stall_left <= $urandom_range(0, 14);
			tok_stall <= 1'b1;
		end else begin
			tok_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		tvsp_pkg::tok_beat_t want;
		if (arst_n && tok_valid && !tok_stall) begin
			if (tokens_due.size() == 0) begin
				$display("%0t: unexpected token beat %h", $time, tok_beat);
				fail_count++;
			end else begin
				want = tokens_due.pop_front();
				if (want.token_kind !== tok_beat.token_kind ||
						want.token_value !== tok_beat.token_value ||
						want.token_depth !== tok_beat.token_depth ||
						want.is_key !== tok_beat.is_key ||
						want.levels_closed !== tok_beat.levels_closed ||
						want.message_done !== tok_beat.message_done ||
						want.error_code !== tok_beat.error_code) begin
					$display("%0t: token mismatch expected %h actual %h",
						$time, want, tok_beat);
					fail_count++;
				end
			end
		end
	end

	// ---------------------------------------------------------------
	// Stimulus
	// ---------------------------------------------------------------
	task automatic wait_drained();
		while (bytes_to_send.size() > 0 || byte_valid || tokens_due.size() > 0)
			@(posedge clk);
	endtask

	initial begin
		int k;
		parser_clear();
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: scalars and extremes
		send_raw(tvsp_pkg::TAG_NULL, 0);
		send_raw(TAG_FALSE, 0);
		send_raw(tvsp_pkg::TAG_TRUE, 0);
		put_int(64'h7FFF_FFFF_FFFF_FFFF); send_msg();
		put_int(64'h8000_0000_0000_0000); send_msg();
		put_dbl(); send_msg();
		// double short at the tag
		send_raw(tvsp_pkg::TAG_DBL, 7);
		// overlong varint: ten bytes, last > 1
		msg.push_back(tvsp_pkg::TAG_INT);
		repeat (9) msg.push_back(8'hFF);
		msg.push_back(8'h02);
		send_msg();
		// largest byte, bad tag, and full bytes_after
		send_raw(8'hFF, 32'hFFFF_FFFF);
		send_raw(TAG_BAD, 0);
		send_raw(tvsp_pkg::TAG_UNUSED, 0);
		// count too large: string and object
		send_raw(tvsp_pkg::TAG_STR, 2); send_raw(8'd3, 1); send_raw(8'h41, 0);
		send_raw(tvsp_pkg::TAG_OBJ, 3); send_raw(8'd2, 2); send_raw(tvsp_pkg::TAG_STR, 1);
		send_raw(8'd0, 0);
		// key not string, and bad tag at key position
		send_raw(tvsp_pkg::TAG_OBJ, 3); send_raw(8'd1, 2); send_raw(tvsp_pkg::TAG_INT, 1);
		send_raw(8'd0, 0);
		send_raw(tvsp_pkg::TAG_OBJ, 3); send_raw(8'd1, 2);
		send_raw(tvsp_pkg::TAG_UNUSED, 1);
		send_raw(8'd0, 0);
		// trailing byte, and a sequence count beyond the bytes left
		send_raw(tvsp_pkg::TAG_NULL, 1); send_raw(tvsp_pkg::TAG_NULL, 0);
		send_raw(tvsp_pkg::TAG_SEQ, 1); send_raw(8'd1, 0);
		// nested object with empty containers and key strings
		msg.push_back(tvsp_pkg::TAG_OBJ); put_varint(64'd2);
		put_str(2); msg.push_back(tvsp_pkg::TAG_SET); put_varint(64'd0);
		put_str(0); msg.push_back(tvsp_pkg::TAG_SEQ); put_varint(64'd1);
		put_str(3);
		send_msg();
		// depth: 32 nested one-element sequences, then one more
		for (int d = 0; d < DEPTH_LIMIT; d++) begin
			msg.push_back(tvsp_pkg::TAG_SEQ); put_varint(64'd1);
		end
		msg.push_back(tvsp_pkg::TAG_NULL);
		send_msg();
		for (int d = 0; d <= DEPTH_LIMIT; d++) begin
			msg.push_back(tvsp_pkg::TAG_SEQ); put_varint(64'd1);
		end
		msg.push_back(tvsp_pkg::TAG_NULL);
		send_msg();
		wait_drained();

		// receiver holds off while sender keeps offering
		hold_go = 1;
		repeat (6) begin
			put_value(0); send_msg();
		end
		wait_drained();

		// random messages; mostly well formed
		while (beats_sent < 450) begin
			put_value(0);
			k = $urandom_range(0, 9);
			if (k < 2)
				damage_msg();
			send_msg();
			if (k == 9)
				send_raw(8'($urandom_range(0, 255)), $urandom);
			if ($urandom_range(0, 30) == 0) begin
				// sender pause until all tokens are in
				hold_sender = 1;
				while (tokens_due.size() > 0 || byte_valid)
					@(posedge clk);
				hold_sender = 0;
			end
			while (bytes_to_send.size() > 20)
				@(posedge clk);
		end
		// calm tail
		quiet_tail = 1;
		repeat (5) begin
			put_value(0); send_msg();
		end
		wait_drained();
		repeat (50) @(posedge clk);
		if (fail_count == 0)
			$display("PASS tagged_value_stream_parser_top");
		else
			$display("FAIL tagged_value_stream_parser_top");
		$finish;
	end

	initial begin
		#3000000;
		$display("FAIL tagged_value_stream_parser_top");
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/tvsp_pkg.sv
rtl/tvsp_stack.sv
rtl/tagged_value_stream_parser_top.sv
rtl/tvsp_check.sv
verif/tagged_value_stream_parser_top_test.sv
